// ----- src/srl_pkg.sv -----
// Shared types and sizing constants for the stable rank labeler.
// Used by srl_cell, srl_rank_sum and stable_rank_labeler; depends on nothing.
package srl_pkg;

    localparam int MAX_ITEMS  = 64;
    localparam int VALUE_W    = 32;
    localparam int RANK_OUT_W = 6;
    localparam int RANK_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
    localparam int GRP_SIZE   = 8;
    localparam int NUM_GRP    = (MAX_ITEMS + GRP_SIZE - 1) / GRP_SIZE;
    localparam int GSUM_W     = $clog2(GRP_SIZE + 1);

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last_value;
    } item_t;

    typedef struct packed {
        logic [RANK_OUT_W-1:0] rank;
        logic                  last_rank;
    } result_t;

    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] value;
        logic [RANK_W-1:0]         rank;
    } cell_t;

endpackage

// ----- src/srl_cell.sv -----
// One storage cell of the rank chain: holds a value, its running rank and a valid bit.
// Depends on srl_pkg for the cell type and widths.
module srl_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              shift,
    input  srl_pkg::cell_t                    upper,
    input  logic                              probe_en,
    input  logic signed [srl_pkg::VALUE_W-1:0] probe,
    input  logic [srl_pkg::RANK_W-1:0]        pend,
    output srl_pkg::cell_t                    cur,
    output srl_pkg::cell_t                    upd,
    output logic                              le
);

    logic                               valid_reg;
    logic                               valid_next;
    logic signed [srl_pkg::VALUE_W-1:0] value_reg;
    logic signed [srl_pkg::VALUE_W-1:0] value_next;
    logic [srl_pkg::RANK_W-1:0]         rank_reg;
    logic [srl_pkg::RANK_W-1:0]         rank_next;
    logic                               inc;

    // A stored value larger than the incoming one moves up one rank.
    assign inc = probe_en && valid_reg && (value_reg > probe);
    assign le  = valid_reg && (value_reg <= probe);

    always_comb
    begin
        cur.valid = valid_reg;
        cur.value = value_reg;
        cur.rank  = rank_reg;
        upd.valid = valid_reg;
        upd.value = value_reg;
        upd.rank  = rank_reg + srl_pkg::RANK_W'(inc) + pend;
    end

    always_comb
    begin
        if (shift)
        begin
            valid_next = upper.valid;
            value_next = upper.value;
            rank_next  = upper.rank;
        end
        else
        begin
            valid_next = upd.valid;
            value_next = upd.value;
            rank_next  = upd.rank;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        rank_reg  <= rank_next;
    end

endmodule

// ----- src/srl_rank_sum.sv -----
// Two-stage count of stored values not above a new value: group counts are registered,
// then summed the next cycle. Depends on srl_pkg for sizing constants.
module srl_rank_sum (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           capture,
    input  logic [srl_pkg::MAX_ITEMS-1:0]  le,
    output logic [srl_pkg::RANK_W-1:0]     pend
);

    logic [srl_pkg::GSUM_W-1:0] grp_reg  [srl_pkg::NUM_GRP];
    logic [srl_pkg::GSUM_W-1:0] grp_next [srl_pkg::NUM_GRP];
    logic                       pend_valid_reg;
    logic                       pend_valid_next;
    logic [srl_pkg::CNT_W-1:0]  total;

    always_comb
    begin
        for (int g = 0; g < srl_pkg::NUM_GRP; g++)
        begin
            grp_next[g] = '0;
            for (int b = 0; b < srl_pkg::GRP_SIZE; b++)
            begin
                if (g * srl_pkg::GRP_SIZE + b < srl_pkg::MAX_ITEMS)
                begin
                    grp_next[g] = grp_next[g]
                        + srl_pkg::GSUM_W'(le[g * srl_pkg::GRP_SIZE + b]);
                end
            end
        end
    end

    assign pend_valid_next = capture;

    always_comb
    begin
        total = '0;
        for (int g = 0; g < srl_pkg::NUM_GRP; g++)
        begin
            total = total + srl_pkg::CNT_W'(grp_reg[g]);
        end
        pend = pend_valid_reg ? srl_pkg::RANK_W'(total) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < srl_pkg::NUM_GRP; g++)
        begin
            grp_reg[g] <= grp_next[g];
        end
    end

endmodule

// ----- src/stable_rank_labeler.sv -----
// Top level of the stable rank labeler: a chain of rank cells, the rank adder and control.
// Depends on srl_pkg, srl_cell and srl_rank_sum.
//
//  channel  | signals                         | payload
//  ---------+---------------------------------+-------------------------
//  item     | item_valid / item_ready         | srl_pkg::item_t   item
//  result   | result_valid / result_ready     | srl_pkg::result_t result
//
// Loading takes one request per cycle; every stored cell compares itself with the
// incoming value in the same cycle, and the new value's own count lands the cycle after.
// After the final value the chain shifts toward cell 0, skipping empty cells and sending
// out one result per cycle in arrival order while the output is free; no request is taken
// meanwhile. A stalled result only holds the chain while a stored cell waits at cell 0.
// Reset empties the chain and the output register.
module stable_rank_labeler (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  srl_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output srl_pkg::result_t result
);

    localparam logic ST_LOAD  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic                          state_reg;
    logic                          state_next;
    logic [srl_pkg::CNT_W-1:0]     count_reg;
    logic [srl_pkg::CNT_W-1:0]     count_next;
    logic [srl_pkg::CNT_W-1:0]     count_inc;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    srl_pkg::result_t              result_reg;
    srl_pkg::result_t              result_next;

    logic                          accept;
    logic                          out_free;
    logic                          emit;
    logic                          shift;
    logic [srl_pkg::RANK_W-1:0]    pend;
    logic [srl_pkg::MAX_ITEMS-1:0] le;
    srl_pkg::cell_t                cur   [srl_pkg::MAX_ITEMS];
    srl_pkg::cell_t                upd   [srl_pkg::MAX_ITEMS];
    srl_pkg::cell_t                upper [srl_pkg::MAX_ITEMS];
    srl_pkg::cell_t                entry;

    assign item_ready   = (state_reg == ST_LOAD);
    assign accept       = item_valid && item_ready;
    assign out_free     = !out_valid_reg || result_ready;
    assign emit         = (state_reg == ST_DRAIN) && cur[0].valid && out_free;
    assign shift        = accept || ((state_reg == ST_DRAIN) && (!cur[0].valid || out_free));
    assign result_valid = out_valid_reg;
    assign result       = result_reg;
    assign count_inc    = count_reg + srl_pkg::CNT_W'(1);

    // A new value enters at the top of the chain; while draining, empty cells enter.
    always_comb
    begin
        entry.valid = accept;
        entry.value = item.value;
        entry.rank  = '0;
    end

    genvar i;
    generate
        for (i = 0; i < srl_pkg::MAX_ITEMS; i++)
        begin : g_cell
            if (i == srl_pkg::MAX_ITEMS - 1)
            begin : g_top
                assign upper[i] = entry;
                srl_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift    (shift),
                    .upper    (upper[i]),
                    .probe_en (accept),
                    .probe    (item.value),
                    .pend     (pend),
                    .cur      (cur[i]),
                    .upd      (upd[i]),
                    .le       (le[i])
                );
            end
            else
            begin : g_body
                assign upper[i] = upd[i+1];
                srl_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift    (shift),
                    .upper    (upper[i]),
                    .probe_en (accept),
                    .probe    (item.value),
                    .pend     ('0),
                    .cur      (cur[i]),
                    .upd      (upd[i]),
                    .le       (le[i])
                );
            end
        end
    endgenerate

    srl_rank_sum u_rank_sum (
        .clk     (clk),
        .rst_n   (rst_n),
        .capture (accept),
        .le      (le),
        .pend    (pend)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        result_next    = result_reg;

        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    count_next = count_inc;
                    // A final-flagged value, or one that fills the last free cell, closes the sequence.
                    if (item.last_value
                        || (count_inc == srl_pkg::CNT_W'(srl_pkg::MAX_ITEMS)))
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (emit)
                begin
                    out_valid_next        = 1'b1;
                    result_next.rank      = srl_pkg::RANK_OUT_W'(cur[0].rank);
                    result_next.last_rank = (count_reg == srl_pkg::CNT_W'(1));
                    count_next            = count_reg - srl_pkg::CNT_W'(1);
                    if (count_reg == srl_pkg::CNT_W'(1))
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule

// ----- tb/stable_rank_checker.sv -----
`timescale 1ns / 100ps
// Checker for the stable rank labeler: watches the request and result channels,
// predicts each sequence's ranks and compares them in order. Depends on srl_pkg.
module stable_rank_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic             item_ready,
    input  srl_pkg::item_t   item,
    input  logic             result_valid,
    input  logic             result_ready,
    input  srl_pkg::result_t result,
    output int               fail_count,
    output int               ranks_pending
);

    localparam int REPORT_LIMIT = 10;

    logic signed [srl_pkg::VALUE_W-1:0] seq_values [srl_pkg::MAX_ITEMS];
    int unsigned                        seq_ranks  [srl_pkg::MAX_ITEMS];
    int unsigned                        seq_len;
    srl_pkg::result_t                   expected_ranks [$];

    initial
    begin
        fail_count    = 0;
        ranks_pending = 0;
        seq_len       = 0;
    end

    task automatic note_failure(input string msg);
        if (fail_count < REPORT_LIMIT)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        fail_count++;
    endtask

    // Each new value ranks above every stored value that is less or equal, and
    // pushes every larger stored value one place up.
    task automatic absorb_value(input srl_pkg::item_t req);
        int unsigned      slot;
        int unsigned      own;
        bit               closes;
        srl_pkg::result_t r;
        slot   = seq_len;
        own    = 0;
        closes = req.last_value;
        if (slot >= srl_pkg::MAX_ITEMS)
            slot = srl_pkg::MAX_ITEMS - 1;
        for (int i = 0; i < slot; i++)
        begin
            if (seq_values[i] <= $signed(req.value))
                own++;
            else
                seq_ranks[i]++;
        end
        seq_values[slot] = $signed(req.value);
        seq_ranks[slot]  = own;
        seq_len          = slot + 1;
        // A full store closes the sequence whatever the flag says.
        if (seq_len >= srl_pkg::MAX_ITEMS)
            closes = 1'b1;
        if (closes)
        begin
            for (int i = 0; i < seq_len; i++)
            begin
                r.rank      = srl_pkg::RANK_OUT_W'(seq_ranks[i]);
                r.last_rank = (i + 1 == seq_len);
                expected_ranks.push_back(r);
            end
            seq_len = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        srl_pkg::result_t exp_r;
        if (!rst_n)
        begin
            seq_len = 0;
            expected_ranks.delete();
        end
        else
        begin
            // Results are checked before the request of the same edge is absorbed,
            // since they always belong to an earlier sequence.
            if (result_valid && result_ready)
            begin
                if (expected_ranks.size() == 0)
                    note_failure($sformatf("unexpected result rank %0d last %0b",
                                           result.rank, result.last_rank));
                else
                begin
                    exp_r = expected_ranks.pop_front();
                    if (result.rank !== exp_r.rank || result.last_rank !== exp_r.last_rank)
                        note_failure($sformatf("rank exp %0d got %0d, last exp %0b got %0b",
                                               exp_r.rank, result.rank,
                                               exp_r.last_rank, result.last_rank));
                end
            end
            if (item_valid && item_ready)
                absorb_value(item);
        end
        ranks_pending = expected_ranks.size();
    end

endmodule

// ----- tb/stable_rank_labeler_tb.sv -----
`timescale 1ns / 100ps
// Top of the stable rank labeler testbench: clock, reset, request and result drivers.
// Depends on srl_pkg, stable_rank_labeler and stable_rank_checker.
module stable_rank_labeler_tb;

    localparam int          ITEM_TARGET = 430;
    localparam int          CYCLE_LIMIT = 300000;
    localparam int          LONG_HOLD   = 400;
    localparam logic signed [srl_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [srl_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             item_valid   = 1'b0;
    logic             item_ready;
    srl_pkg::item_t   item         = '0;
    logic             result_valid;
    logic             result_ready = 1'b0;
    srl_pkg::result_t result;
    int               fail_count;
    int               ranks_pending;
    int               items_sent   = 0;
    int               cycle_count  = 0;

    always #5 clk = ~clk;

    stable_rank_labeler uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    stable_rank_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item          (item),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result),
        .fail_count    (fail_count),
        .ranks_pending (ranks_pending)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    // Mix of full-range values, a narrow band that forces ties, and extremes.
    function automatic logic signed [srl_pkg::VALUE_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom();
        else if (r < 80)
            return int'($urandom_range(0, 8)) - 4;
        case ($urandom_range(0, 3))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return '0;
            default: return -1;
        endcase
    endfunction

    task automatic offer_item(input logic signed [srl_pkg::VALUE_W-1:0] v, input logic fin);
        int unsigned gap;
        item       <= '{value: v, last_value: fin};
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        items_sent++;
        gap = idle_len();
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side: random stalls, stretches at full speed, and one long hold-off
    // while a sequence is being sent out, so the block backs up onto its input.
    initial
    begin
        int unsigned r;
        int          rounds;
        bit          held;
        rounds = 0;
        held   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            r = $urandom_range(0, 99);
            if (!held && rounds > 20 && ranks_pending > 0)
            begin
                held = 1'b1;
                result_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (r < 45)
            begin
                result_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
            else if (r < 55)
            begin
                result_ready <= 1'b1;
                repeat ($urandom_range(50, 100)) @(posedge clk);
            end
            else if (r < 92)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(10, 30)) @(posedge clk);
            end
            rounds++;
        end
    end

    initial
    begin
        int unsigned r;
        int unsigned len;
        bit          fin;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-element sequences at both extremes.
        offer_item(VAL_MAX, 1'b1);
        offer_item(VAL_MIN, 1'b1);
        // Extremes mixed with repeated values.
        offer_item(0, 1'b0);
        offer_item(-1, 1'b0);
        offer_item(VAL_MAX, 1'b0);
        offer_item(VAL_MIN, 1'b0);
        offer_item(-1, 1'b0);
        offer_item(0, 1'b0);
        offer_item(5, 1'b1);
        // All equal: ranks follow arrival order.
        repeat (3) offer_item(7, 1'b0);
        offer_item(7, 1'b1);
        // Strictly descending, then strictly ascending.
        offer_item(3, 1'b0);
        offer_item(2, 1'b0);
        offer_item(1, 1'b1);
        offer_item(1, 1'b0);
        offer_item(2, 1'b0);
        offer_item(3, 1'b1);
        // Alternating bit patterns.
        offer_item(32'sh5555_5555, 1'b0);
        offer_item(32'shAAAA_AAAA, 1'b1);

        // A sequence with no final flag fills the store and closes itself.
        repeat (srl_pkg::MAX_ITEMS) offer_item(pick_value(), 1'b0);

        while (items_sent < ITEM_TARGET)
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
                len = $urandom_range(1, 16);
            else if (r < 95)
                len = $urandom_range(17, srl_pkg::MAX_ITEMS - 1);
            else
                len = $urandom_range(srl_pkg::MAX_ITEMS, srl_pkg::MAX_ITEMS + 6);
            for (int k = 1; k <= len; k++)
            begin
                fin = (k == len) && (len < srl_pkg::MAX_ITEMS || $urandom_range(0, 1) == 1);
                offer_item(pick_value(), fin);
            end
        end
        offer_item(pick_value(), 1'b1);
        item_valid <= 1'b0;

        @(posedge clk);
        wait (ranks_pending == 0);
        repeat (srl_pkg::MAX_ITEMS + 16) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- stable_rank_labeler.f -----
src/srl_pkg.sv
src/srl_cell.sv
src/srl_rank_sum.sv
src/stable_rank_labeler.sv
tb/stable_rank_checker.sv
tb/stable_rank_labeler_tb.sv
